### hw/rtl/cht_pkg.sv
// Shared types and constants for the cuckoo hash table unit.
// No dependencies; imported by cht_ctrl, cht_datapath and cuckoo_hash_table_unit.
package cht_pkg;

    localparam int KEY_W         = 32;
    localparam int VALUE_W       = 32;
    localparam int STATUS_W      = 3;
    localparam int ENTRY_COUNT_W = 12;
    localparam int KICK_W        = 11;

    localparam logic [KICK_W-1:0] KICK_LIMIT_RESET = 11'd1024;
    localparam logic              REQ_INSERT       = 1'b0;
    localparam logic              REQ_REMOVE       = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_INSERTED  = 3'd0,
        ST_UPDATED   = 3'd1,
        ST_REMOVED   = 3'd2,
        ST_NOT_FOUND = 3'd3,
        ST_FULL      = 3'd4
    } t_status;

    typedef struct packed {
        logic               req_type;
        logic [KEY_W-1:0]   key;
        logic [VALUE_W-1:0] value;
    } t_req;

    typedef struct packed {
        logic [STATUS_W-1:0]      status;
        logic [ENTRY_COUNT_W-1:0] entry_count;
        logic [KEY_W-1:0]         dropped_key;
        logic [VALUE_W-1:0]       dropped_value;
    } t_rsp;

    typedef struct packed {
        logic               valid;
        logic [KEY_W-1:0]   key;
        logic [VALUE_W-1:0] value;
    } t_slot;

    // Controller to datapath
    typedef struct packed {
        logic    load;
        logic    rd1;
        logic    rd2;
        logic    wr1;
        logic    wr2;
        logic    clr1;
        logic    clr2;
        logic    cnt_inc;
        logic    cnt_dec;
        logic    round_clr;
        logic    round_inc;
        logic    clear_step;
        logic    rsp_load;
        t_status code;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic is_remove;
        logic hit1;
        logic hit2;
        logic occ1;
        logic occ2;
        logic last_round;
        logic clear_done;
    } t_stat;

endpackage

### hw/rtl/cuckoo_hash_table_unit.sv
// Cuckoo hash table unit: top level joining cht_ctrl and cht_datapath.
// Depends on cht_pkg, cht_ctrl and cht_datapath.
//
// Two tables of CAPACITY slots each (table one indexed by the low key bits,
// table two by the next key bits) hold 32-bit key/value pairs, one request
// at a time. After reset a clearing pass invalidates both tables; no request
// is taken until it ends, while kick limit writes are taken at any time.
// An insert that evicts reads and writes table two for the first move (the
// table one write happens in the lookup cycle), and reads and writes each
// table on every later round, for at most kick_limit rounds, a zero limit
// counting as one round. Each table has a single read/write port with
// registered read data. A finished response waits in an output register,
// and the next request is accepted meanwhile; that request holds in its
// final cycle until the register drains.
module cuckoo_hash_table_unit #(
    parameter int CAPACITY = 1024
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_req_valid,
    output logic                       o_req_ready,
    input  cht_pkg::t_req              i_req,
    output logic                       o_rsp_valid,
    input  logic                       i_rsp_ready,
    output cht_pkg::t_rsp              o_rsp,
    input  logic                       i_cfg_we,
    input  logic [cht_pkg::KICK_W-1:0] i_cfg_wdata
);
    import cht_pkg::*;

    t_cmd  w_cmd;
    t_stat w_stat;

    cht_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_ready (o_req_ready),
        .o_rsp_valid (o_rsp_valid),
        .i_rsp_ready (i_rsp_ready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    cht_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .i_req       (i_req),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_rsp       (o_rsp)
    );

endmodule

### hw/rtl/cht_datapath.sv
// Datapath of the cuckoo hash table: both slot memories, the carried pair,
// occupancy, eviction round count, kick limit register and response register. Uses cht_pkg.
module cht_datapath #(
    parameter int CAPACITY = 1024
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  cht_pkg::t_cmd                      i_cmd,
    output cht_pkg::t_stat                     o_stat,
    input  cht_pkg::t_req                      i_req,
    input  logic                               i_cfg_we,
    input  logic [cht_pkg::KICK_W-1:0]         i_cfg_wdata,
    output cht_pkg::t_rsp                      o_rsp
);
    import cht_pkg::*;

    localparam int IDX_W   = $clog2(CAPACITY);
    localparam int CNT_RAW = $clog2(2 * CAPACITY + 1);
    localparam int CNT_W   = (CNT_RAW > ENTRY_COUNT_W) ? CNT_RAW : ENTRY_COUNT_W;

    t_slot r_mem1 [CAPACITY];
    t_slot r_mem2 [CAPACITY];

    t_slot               r_rd1;
    t_slot               r_rd2;
    logic                r_type;
    logic [KEY_W-1:0]    r_key;
    logic [VALUE_W-1:0]  r_val;
    logic [CNT_W-1:0]    r_count;
    logic [KICK_W-1:0]   r_kick;
    logic [KICK_W-1:0]   r_round;
    logic [IDX_W-1:0]    r_clr_addr;
    t_rsp                r_rsp;

    logic [IDX_W-1:0]    w_idx1;
    logic [IDX_W-1:0]    w_idx2;
    logic [IDX_W-1:0]    w_addr1;
    logic [IDX_W-1:0]    w_addr2;
    logic                w_we1;
    logic                w_we2;
    t_slot               w_wdata;
    logic [KICK_W-1:0]   w_eff_limit;

    assign w_idx1  = r_key[IDX_W-1:0];
    assign w_idx2  = r_key[2*IDX_W-1:IDX_W];
    assign w_addr1 = i_cmd.clear_step ? r_clr_addr : w_idx1;
    assign w_addr2 = i_cmd.clear_step ? r_clr_addr : w_idx2;
    assign w_we1   = i_cmd.wr1 | i_cmd.clr1 | i_cmd.clear_step;
    assign w_we2   = i_cmd.wr2 | i_cmd.clr2 | i_cmd.clear_step;

    // place and update both store the carried pair; clears drop the valid bit
    always_comb begin
        w_wdata.valid = i_cmd.wr1 | i_cmd.wr2;
        w_wdata.key   = r_key;
        w_wdata.value = r_val;
    end

    always_ff @(posedge i_clk) begin
        if (w_we1) begin
            r_mem1[w_addr1] <= w_wdata;
        end
        if (i_cmd.rd1) begin
            r_rd1 <= r_mem1[w_idx1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we2) begin
            r_mem2[w_addr2] <= w_wdata;
        end
        if (i_cmd.rd2) begin
            r_rd2 <= r_mem2[w_idx2];
        end
    end

    // Carried pair: swap with the occupant on every placement
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_type <= i_req.req_type;
            r_key  <= i_req.key;
            r_val  <= i_req.value;
        end else if (i_cmd.wr1) begin
            r_key <= r_rd1.key;
            r_val <= r_rd1.value;
        end else if (i_cmd.wr2) begin
            r_key <= r_rd2.key;
            r_val <= r_rd2.value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_kick     <= KICK_LIMIT_RESET;
            r_round    <= '0;
            r_clr_addr <= '0;
        end else begin
            if (i_cmd.cnt_inc) begin
                r_count <= r_count + CNT_W'(1);
            end else if (i_cmd.cnt_dec) begin
                r_count <= r_count - CNT_W'(1);
            end
            if (i_cfg_we) begin
                r_kick <= i_cfg_wdata;
            end
            if (i_cmd.round_clr) begin
                r_round <= '0;
            end else if (i_cmd.round_inc) begin
                r_round <= r_round + KICK_W'(1);
            end
            if (i_cmd.clear_step) begin
                r_clr_addr <= r_clr_addr + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rsp_load) begin
            r_rsp.status      <= i_cmd.code;
            r_rsp.entry_count <= r_count[ENTRY_COUNT_W-1:0];
            if (i_cmd.code == ST_FULL) begin
                r_rsp.dropped_key   <= r_key;
                r_rsp.dropped_value <= r_val;
            end else begin
                r_rsp.dropped_key   <= '0;
                r_rsp.dropped_value <= '0;
            end
        end
    end

    // a zero limit still allows one round
    assign w_eff_limit = (r_kick == '0) ? KICK_W'(1) : r_kick;

    always_comb begin
        o_stat.is_remove  = (r_type == REQ_REMOVE);
        o_stat.hit1       = r_rd1.valid && (r_rd1.key == r_key);
        o_stat.hit2       = r_rd2.valid && (r_rd2.key == r_key);
        o_stat.occ1       = r_rd1.valid;
        o_stat.occ2       = r_rd2.valid;
        o_stat.last_round = (r_round == w_eff_limit - KICK_W'(1));
        o_stat.clear_done = (r_clr_addr == '1);
    end

    assign o_rsp = r_rsp;

endmodule

### hw/rtl/cht_ctrl.sv
// Controller of the cuckoo hash table: sequences lookup, update, remove and
// eviction rounds, the post-reset clearing pass and the request/response handshakes. Uses cht_pkg.
module cht_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_req_valid,
    output logic           o_req_ready,
    output logic           o_rsp_valid,
    input  logic           i_rsp_ready,
    input  cht_pkg::t_stat i_stat,
    output cht_pkg::t_cmd  o_cmd
);
    import cht_pkg::*;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_CHECK,
        S_RD2,
        S_PUT2,
        S_RD1,
        S_PUT1,
        S_RESP
    } t_state;

    t_state  r_state;
    t_state  n_state;
    t_status r_code;
    t_status n_code;
    logic    r_req_ready;
    logic    n_req_ready;
    logic    r_rsp_valid;
    logic    n_rsp_valid;
    t_cmd    w_cmd;

    always_comb begin
        n_state = r_state;
        n_code  = r_code;
        w_cmd   = '0;
        w_cmd.code = r_code;
        case (r_state)
            S_CLEAR: begin
                w_cmd.clear_step = 1'b1;
                if (i_stat.clear_done) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_req_valid) begin
                    w_cmd.load = 1'b1;
                    n_state    = S_READ;
                end
            end
            S_READ: begin
                w_cmd.rd1 = 1'b1;
                w_cmd.rd2 = 1'b1;
                n_state   = S_CHECK;
            end
            S_CHECK: begin
                n_state = S_RESP;
                if (i_stat.is_remove) begin
                    if (i_stat.hit1) begin
                        w_cmd.clr1    = 1'b1;
                        w_cmd.cnt_dec = 1'b1;
                        n_code        = ST_REMOVED;
                    end else if (i_stat.hit2) begin
                        w_cmd.clr2    = 1'b1;
                        w_cmd.cnt_dec = 1'b1;
                        n_code        = ST_REMOVED;
                    end else begin
                        n_code = ST_NOT_FOUND;
                    end
                end else if (i_stat.hit1) begin
                    w_cmd.wr1 = 1'b1;
                    n_code    = ST_UPDATED;
                end else if (i_stat.hit2) begin
                    w_cmd.wr2 = 1'b1;
                    n_code    = ST_UPDATED;
                end else begin
                    // first placement of round zero uses the lookup data
                    w_cmd.wr1       = 1'b1;
                    w_cmd.round_clr = 1'b1;
                    if (!i_stat.occ1) begin
                        w_cmd.cnt_inc = 1'b1;
                        n_code        = ST_INSERTED;
                    end else begin
                        n_state = S_RD2;
                    end
                end
            end
            S_RD2: begin
                w_cmd.rd2 = 1'b1;
                n_state   = S_PUT2;
            end
            S_PUT2: begin
                w_cmd.wr2 = 1'b1;
                if (!i_stat.occ2) begin
                    w_cmd.cnt_inc = 1'b1;
                    n_code        = ST_INSERTED;
                    n_state       = S_RESP;
                end else if (i_stat.last_round) begin
                    n_code  = ST_FULL;
                    n_state = S_RESP;
                end else begin
                    w_cmd.round_inc = 1'b1;
                    n_state         = S_RD1;
                end
            end
            S_RD1: begin
                w_cmd.rd1 = 1'b1;
                n_state   = S_PUT1;
            end
            S_PUT1: begin
                w_cmd.wr1 = 1'b1;
                if (!i_stat.occ1) begin
                    w_cmd.cnt_inc = 1'b1;
                    n_code        = ST_INSERTED;
                    n_state       = S_RESP;
                end else begin
                    n_state = S_RD2;
                end
            end
            S_RESP: begin
                // hold until the output register is free
                if (!r_rsp_valid || i_rsp_ready) begin
                    w_cmd.rsp_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        n_req_ready = (n_state == S_IDLE);
        n_rsp_valid = w_cmd.rsp_load || (r_rsp_valid && !i_rsp_ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_code      <= ST_INSERTED;
            r_req_ready <= 1'b0;
            r_rsp_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_code      <= n_code;
            r_req_ready <= n_req_ready;
            r_rsp_valid <= n_rsp_valid;
        end
    end

    assign o_cmd       = w_cmd;
    assign o_req_ready = r_req_ready;
    assign o_rsp_valid = r_rsp_valid;

endmodule
